/* rtl/core/sdrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdrt_pkg;

    // Awaited completion stage
    localparam logic [2:0] STG_NONE     = 3'd0;
    localparam logic [2:0] STG_CMDSENT  = 3'd1;
    localparam logic [2:0] STG_RSPFIN   = 3'd2;
    localparam logic [2:0] STG_XFER     = 3'd3;
    localparam logic [2:0] STG_XFER_RSP = 3'd4;

    // Request action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_IRQ   = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_POP    = 2'd0;
    localparam logic [1:0] KIND_PUSH   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Command error codes
    localparam logic [1:0] CERR_NONE    = 2'd0;
    localparam logic [1:0] CERR_TIMEOUT = 2'd1;
    localparam logic [1:0] CERR_CRC     = 2'd2;

    // Data error codes
    localparam logic [1:0] DERR_NONE    = 2'd0;
    localparam logic [1:0] DERR_FIFO    = 2'd1;
    localparam logic [1:0] DERR_CRC     = 2'd2;
    localparam logic [1:0] DERR_TIMEOUT = 2'd3;

    // Word moves per interrupt are capped so the word count always fits in WORD_CNT_W bits
    localparam int WORD_CNT_W = 5;
    localparam int WORD_CAP   = 31;

    // Outcome of one interrupt request
    typedef struct packed {
        logic [2:0]            stage;
        logic [1:0]            cmd_err;
        logic [1:0]            data_err;
        logic [WORD_CNT_W-1:0] words;
        logic [1:0]            word_kind;
        logic                  bounded;
        logic                  done;
        logic [3:0]            cmd_clr;
        logic                  xfer_clr;
        logic                  rx_ack;
        logic                  fifo_rst;
        logic                  irq_off;
    } t_decision;

endpackage

`default_nettype wire

/* rtl/core/sd_host_request_completion_tracker_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Start request: capture, then the decide state, then back to ready; no result.
// Interrupt request: capture, decode, then one word result per cycle while the output
// is not stalled (up to 31, through one shared offset adder and compare), a check of the
// end of the burst and the status result.
// Reset (synchronous, active low) clears the tracker state and drops any pending result.
module sd_host_request_completion_tracker_top #(
    parameter int TX_BURST_WORDS  = 16,
    parameter int RX_FULL_WORDS   = 8,
    parameter int BYTE_COUNT_BITS = 17
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic        i_needs_response,
    input  wire logic        i_check_crc,
    input  wire logic        i_has_data,
    input  wire logic        i_is_read,
    input  wire logic [7:0]  i_block_count,
    input  wire logic [3:0]  i_block_size_log2,
    input  wire logic [3:0]  i_cmd_status,
    input  wire logic [8:0]  i_data_status,
    input  wire logic [6:0]  i_fifo_level,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_byte_offset,
    output logic [1:0]       o_cmd_error,
    output logic [1:0]       o_data_error,
    output logic             o_req_complete,
    output logic [3:0]       o_cmd_clear_mask,
    output logic             o_clear_xfer_finish,
    output logic             o_ack_rx_last,
    output logic             o_fifo_reset,
    output logic             o_irq_mask_off,
    output logic             o_last
);
    import sdrt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_WORD   = 2'd2;
    localparam logic [1:0] S_STATUS = 2'd3;

    localparam int BCB = BYTE_COUNT_BITS;

    // Sequencer and tracker state
    logic [1:0]            r_state, n_state;
    logic [2:0]            r_stage;
    logic [1:0]            r_cmd_err;
    logic [1:0]            r_data_err;
    logic [BCB-1:0]        r_bytes_done;
    logic [BCB-1:0]        r_total_bytes;
    logic                  r_req_has_data;
    logic                  r_req_is_read;
    logic                  r_req_check_crc;
    logic [WORD_CNT_W-1:0] r_words;

    // Captured request and decision payload
    logic       r_action;
    logic       r_needs_response;
    logic       r_check_crc;
    logic       r_has_data;
    logic       r_is_read;
    logic [7:0] r_block_count;
    logic [3:0] r_block_size_log2;
    logic [3:0] r_cmd_status;
    logic [8:0] r_data_status;
    logic [6:0] r_fifo_level;
    t_decision  r_dec;
    t_decision  dec;

    logic in_acc;
    logic out_free;
    logic below_total;
    logic word_go;
    logic status_go;

    sdrt_decode #(
        .TX_BURST_WORDS (TX_BURST_WORDS),
        .RX_FULL_WORDS  (RX_FULL_WORDS)
    ) u_decode (
        .i_stage       (r_stage),
        .i_cmd_err     (r_cmd_err),
        .i_data_err    (r_data_err),
        .i_has_data    (r_req_has_data),
        .i_is_read     (r_req_is_read),
        .i_check_crc   (r_req_check_crc),
        .i_cmd_status  (r_cmd_status),
        .i_data_status (r_data_status),
        .i_fifo_level  (r_fifo_level),
        .o_dec         (dec)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !o_valid || i_ready;
    assign below_total = (r_bytes_done < r_total_bytes);
    assign word_go     = (r_state == S_WORD) && out_free && (r_words != '0)
                         && (!r_dec.bounded || below_total);
    assign status_go   = (r_state == S_STATUS) && out_free;

    // Sequence: capture, decide, move words, report status
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = (r_action == ACT_START) ? S_IDLE : S_WORD;
            end
            S_WORD: begin
                if (out_free && !word_go) n_state = S_STATUS;
            end
            S_STATUS: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action          <= i_action;
            r_needs_response  <= i_needs_response;
            r_check_crc       <= i_check_crc;
            r_has_data        <= i_has_data;
            r_is_read         <= i_is_read;
            r_block_count     <= i_block_count;
            r_block_size_log2 <= i_block_size_log2;
            r_cmd_status      <= i_cmd_status;
            r_data_status     <= i_data_status;
            r_fifo_level      <= i_fifo_level;
        end
        if (r_state == S_DECIDE) begin
            r_dec <= dec;
        end
    end

    // Advance tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_stage         <= STG_NONE;
            r_cmd_err       <= CERR_NONE;
            r_data_err      <= DERR_NONE;
            r_bytes_done    <= '0;
            r_total_bytes   <= '0;
            r_req_has_data  <= 1'b0;
            r_req_is_read   <= 1'b0;
            r_req_check_crc <= 1'b0;
            r_words         <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE) begin
                if (r_action == ACT_START) begin
                    if (r_has_data)            r_stage <= STG_XFER_RSP;
                    else if (r_needs_response) r_stage <= STG_RSPFIN;
                    else                       r_stage <= STG_CMDSENT;
                    r_req_check_crc <= r_check_crc;
                    r_req_has_data  <= r_has_data;
                    r_req_is_read   <= r_is_read;
                    r_cmd_err       <= CERR_NONE;
                    r_data_err      <= DERR_NONE;
                    r_bytes_done    <= '0;
                    r_total_bytes   <= BCB'(r_block_count) << r_block_size_log2;
                end else begin
                    r_stage    <= dec.stage;
                    r_cmd_err  <= dec.cmd_err;
                    r_data_err <= dec.data_err;
                    r_words    <= dec.words;
                end
            end
            if (word_go) begin
                r_words      <= r_words - WORD_CNT_W'(1);
                r_bytes_done <= r_bytes_done + BCB'(4);
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (word_go || status_go) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_go) begin
            o_kind              <= r_dec.word_kind;
            o_byte_offset       <= 16'(r_bytes_done);
            o_cmd_error         <= CERR_NONE;
            o_data_error        <= DERR_NONE;
            o_req_complete      <= 1'b0;
            o_cmd_clear_mask    <= 4'd0;
            o_clear_xfer_finish <= 1'b0;
            o_ack_rx_last       <= 1'b0;
            o_fifo_reset        <= 1'b0;
            o_irq_mask_off      <= 1'b0;
            o_last              <= 1'b0;
        end else if (status_go) begin
            o_kind              <= KIND_STATUS;
            o_byte_offset       <= 16'd0;
            o_cmd_error         <= r_cmd_err;
            o_data_error        <= r_data_err;
            o_req_complete      <= r_dec.done;
            o_cmd_clear_mask    <= r_dec.cmd_clr;
            o_clear_xfer_finish <= r_dec.xfer_clr;
            o_ack_rx_last       <= r_dec.rx_ack;
            o_fifo_reset        <= r_dec.fifo_rst;
            o_irq_mask_off      <= r_dec.irq_off;
            o_last              <= 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sdrt_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdrt_decode #(
    parameter int TX_BURST_WORDS = 16,
    parameter int RX_FULL_WORDS  = 8
) (
    input  wire logic [2:0]          i_stage,
    input  wire logic [1:0]          i_cmd_err,
    input  wire logic [1:0]          i_data_err,
    input  wire logic                i_has_data,
    input  wire logic                i_is_read,
    input  wire logic                i_check_crc,
    input  wire logic [3:0]          i_cmd_status,
    input  wire logic [8:0]          i_data_status,
    input  wire logic [6:0]          i_fifo_level,
    output sdrt_pkg::t_decision      o_dec
);
    import sdrt_pkg::*;

    localparam int TX_N = (TX_BURST_WORDS > WORD_CAP) ? WORD_CAP : TX_BURST_WORDS;
    localparam int RX_N = (RX_FULL_WORDS > WORD_CAP) ? WORD_CAP : RX_FULL_WORDS;

    t_decision d;
    logic      closed;

    // Walk the status flags in priority order; a closure stops the walk
    always_comb begin
        d           = '0;
        d.stage     = i_stage;
        d.cmd_err   = i_cmd_err;
        d.data_err  = i_data_err;
        d.word_kind = KIND_POP;
        closed      = 1'b0;

        if (i_stage < STG_CMDSENT || i_stage > STG_XFER_RSP) begin
            d.irq_off = 1'b1;
        end else begin
            if (i_cmd_status[0]) begin
                d.cmd_err = CERR_TIMEOUT;
                closed    = 1'b1;
            end
            if (!closed && i_cmd_status[1]) begin
                if (d.stage == STG_CMDSENT) begin
                    d.cmd_err = CERR_NONE;
                    closed    = 1'b1;
                end else begin
                    d.cmd_clr[1] = 1'b1;
                end
            end
            if (!closed && i_cmd_status[2]) begin
                if (i_check_crc) begin
                    d.cmd_err = CERR_CRC;
                    closed    = 1'b1;
                end else begin
                    d.cmd_clr[2] = 1'b1;
                end
            end
            if (!closed && i_cmd_status[3]) begin
                if (d.stage == STG_RSPFIN) begin
                    d.cmd_err = CERR_NONE;
                    closed    = 1'b1;
                end else begin
                    if (d.stage == STG_XFER_RSP) begin
                        d.cmd_err = CERR_NONE;
                        d.stage   = STG_XFER;
                    end
                    d.cmd_clr[3] = 1'b1;
                end
            end

            // Data phase failures
            if (!closed) begin
                if (i_data_status[0]) begin
                    d.cmd_err  = CERR_NONE;
                    d.data_err = DERR_FIFO;
                    closed     = 1'b1;
                end else if (i_data_status[1]) begin
                    d.cmd_err  = CERR_NONE;
                    d.data_err = DERR_FIFO;
                    d.fifo_rst = 1'b1;
                    closed     = 1'b1;
                end else if (i_data_status[3:2] != 2'b00) begin
                    d.cmd_err  = CERR_NONE;
                    d.data_err = DERR_CRC;
                    closed     = 1'b1;
                end else if (i_data_status[4]) begin
                    d.cmd_err  = CERR_NONE;
                    d.data_err = DERR_TIMEOUT;
                    closed     = 1'b1;
                end
            end

            // FIFO pumping
            if (!closed && i_has_data) begin
                if (i_is_read) begin
                    if (i_data_status[6]) begin
                        d.words = i_fifo_level[6:2];
                        if (d.stage == STG_XFER) begin
                            d.cmd_err  = CERR_NONE;
                            d.data_err = DERR_NONE;
                            d.xfer_clr = 1'b1;
                            d.rx_ack   = 1'b1;
                            closed     = 1'b1;
                        end
                    end else if (i_data_status[7]) begin
                        d.words = WORD_CNT_W'(RX_N);
                    end
                end else if (i_data_status[8]) begin
                    d.words     = WORD_CNT_W'(TX_N);
                    d.word_kind = KIND_PUSH;
                    d.bounded   = 1'b1;
                end
            end

            // Transfer finish
            if (!closed && i_data_status[5]) begin
                if (d.stage == STG_XFER) begin
                    d.cmd_err  = CERR_NONE;
                    d.data_err = DERR_NONE;
                    d.xfer_clr = 1'b1;
                    d.rx_ack   = 1'b1;
                    closed     = 1'b1;
                end else begin
                    if (d.stage == STG_XFER_RSP) begin
                        d.data_err = DERR_NONE;
                        d.stage    = STG_RSPFIN;
                    end
                    d.xfer_clr = 1'b1;
                end
            end

            // Close the request
            if (closed) begin
                d.cmd_clr = 4'd0;
                d.done    = 1'b1;
                d.irq_off = 1'b1;
                d.stage   = STG_NONE;
                if (i_has_data && d.data_err != DERR_NONE) begin
                    d.fifo_rst = 1'b1;
                end
            end
        end
    end

    assign o_dec = d;

endmodule

`default_nettype wire

/* verif/sd_host_request_completion_tracker_top_tb.sv */
`timescale 1ns / 1ps

module sd_host_request_completion_tracker_top_tb;

    import sdrt_pkg::*;

    localparam int TX_BURST_WORDS  = 16;
    localparam int RX_FULL_WORDS   = 8;
    localparam int BYTE_COUNT_BITS = 17;
    localparam int WORD_BYTES      = 4;
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 8;
    localparam int MAX_WAIT        = 17;
    localparam int RANDOM_ITEMS    = 132;
    localparam int DRAIN_CYCLES    = 48;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic       action;
        logic       needs_response;
        logic       check_crc;
        logic       has_data;
        logic       is_read;
        logic [7:0] block_count;
        logic [3:0] block_size_log2;
        logic [3:0] cmd_status;
        logic [8:0] data_status;
        logic [6:0] fifo_level;
    } tracker_request_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] byte_offset;
        logic [1:0]  cmd_error;
        logic [1:0]  data_error;
        logic        req_complete;
        logic [3:0]  cmd_clear_mask;
        logic        clear_xfer_finish;
        logic        ack_rx_last;
        logic        fifo_reset;
        logic        irq_mask_off;
        logic        last;
    } tracker_result_t;

    // Mirror of the tracker state; predicts the word moves and status of each request
    class completion_scoreboard;
        logic [2:0]                 stage;
        logic [1:0]                 cmd_err;
        logic [1:0]                 data_err;
        logic [BYTE_COUNT_BITS-1:0] bytes_done;
        logic [BYTE_COUNT_BITS-1:0] total_bytes;
        logic                       data_phase;
        logic                       card_read;
        logic                       crc_checked;
        tracker_result_t            awaited_results[$];
        int                         failures;

        function new();
            stage       = STG_NONE;
            cmd_err     = CERR_NONE;
            data_err    = DERR_NONE;
            bytes_done  = '0;
            total_bytes = '0;
            data_phase  = 1'b0;
            card_read   = 1'b0;
            crc_checked = 1'b0;
            failures    = 0;
        endfunction

        function string describe(tracker_result_t r);
            return $sformatf({"kind=%0d off=%h cerr=%0d derr=%0d done=%0b clr=%h ",
                              "xclr=%0b rxack=%0b frst=%0b imoff=%0b last=%0b"},
                             r.kind, r.byte_offset, r.cmd_error, r.data_error,
                             r.req_complete, r.cmd_clear_mask, r.clear_xfer_finish,
                             r.ack_rx_last, r.fifo_reset, r.irq_mask_off, r.last);
        endfunction

        // Queue one moved word at the current offset and advance the counter
        function void add_word(logic [1:0] kind);
            tracker_result_t r;
            r             = '0;
            r.kind        = kind;
            r.byte_offset = bytes_done[15:0];
            bytes_done    = bytes_done + BYTE_COUNT_BITS'(WORD_BYTES);
            awaited_results.push_back(r);
        endfunction

        function void add_status(logic done, logic [3:0] cclr, logic xclr, logic rxack,
                                 logic frst, logic imoff);
            tracker_result_t r;
            r                   = '0;
            r.kind              = KIND_STATUS;
            r.cmd_error         = cmd_err;
            r.data_error        = data_err;
            r.req_complete      = done;
            r.cmd_clear_mask    = cclr;
            r.clear_xfer_finish = xclr;
            r.ack_rx_last       = rxack;
            r.fifo_reset        = frst;
            r.irq_mask_off      = imoff;
            r.last              = 1'b1;
            awaited_results.push_back(r);
        endfunction

        // Close the request; a data request with an error also resets the FIFO
        function void close_request(logic xclr, logic rxack, logic frst);
            if (data_phase && data_err != DERR_NONE) begin
                frst = 1'b1;
            end
            stage = STG_NONE;
            add_status(1'b1, 4'b0000, xclr, rxack, frst, 1'b1);
        endfunction

        function void track_request(tracker_request_t rq);
            logic [3:0] cs;
            logic [8:0] ds;
            logic [3:0] cclr;
            logic       xclr;
            logic [31:0] wide;
            int         n;
            int         i;
            cs   = rq.cmd_status;
            ds   = rq.data_status;
            cclr = 4'b0000;
            xclr = 1'b0;

            // Start: pick the awaited stage and clear the request state
            if (rq.action == ACT_START) begin
                stage = STG_CMDSENT;
                if (rq.needs_response) stage = STG_RSPFIN;
                if (rq.has_data) stage = STG_XFER_RSP;
                crc_checked = rq.check_crc;
                data_phase  = rq.has_data;
                card_read   = rq.is_read;
                cmd_err     = CERR_NONE;
                data_err    = DERR_NONE;
                bytes_done  = '0;
                wide        = 32'(rq.block_count) << rq.block_size_log2;
                total_bytes = wide[BYTE_COUNT_BITS-1:0];
                return;
            end

            // Nothing awaited: mask interrupts only
            if (stage < STG_CMDSENT || stage > STG_XFER_RSP) begin
                add_status(1'b0, 4'b0000, 1'b0, 1'b0, 1'b0, 1'b1);
                return;
            end

            // Command phase flags
            if (cs[0]) begin
                cmd_err = CERR_TIMEOUT;
                close_request(1'b0, 1'b0, 1'b0);
                return;
            end
            if (cs[1]) begin
                if (stage == STG_CMDSENT) begin
                    cmd_err = CERR_NONE;
                    close_request(1'b0, 1'b0, 1'b0);
                    return;
                end
                cclr[1] = 1'b1;
            end
            if (cs[2]) begin
                if (crc_checked) begin
                    cmd_err = CERR_CRC;
                    close_request(1'b0, 1'b0, 1'b0);
                    return;
                end
                cclr[2] = 1'b1;
            end
            if (cs[3]) begin
                if (stage == STG_RSPFIN) begin
                    cmd_err = CERR_NONE;
                    close_request(1'b0, 1'b0, 1'b0);
                    return;
                end
                if (stage == STG_XFER_RSP) begin
                    cmd_err = CERR_NONE;
                    stage   = STG_XFER;
                end
                cclr[3] = 1'b1;
            end

            // Data errors close the request even without a data phase
            if (ds[0]) begin
                cmd_err  = CERR_NONE;
                data_err = DERR_FIFO;
                close_request(1'b0, 1'b0, 1'b0);
                return;
            end
            if (ds[1]) begin
                cmd_err  = CERR_NONE;
                data_err = DERR_FIFO;
                close_request(1'b0, 1'b0, 1'b1);
                return;
            end
            if (ds[2] || ds[3]) begin
                cmd_err  = CERR_NONE;
                data_err = DERR_CRC;
                close_request(1'b0, 1'b0, 1'b0);
                return;
            end
            if (ds[4]) begin
                cmd_err  = CERR_NONE;
                data_err = DERR_TIMEOUT;
                close_request(1'b0, 1'b0, 1'b0);
                return;
            end

            // FIFO pumping
            if (data_phase) begin
                if (card_read) begin
                    if (ds[6]) begin
                        n = int'(rq.fifo_level >> 2);
                        if (n > WORD_CAP) n = WORD_CAP;
                        for (i = 0; i < n; i++) add_word(KIND_POP);
                        if (stage == STG_XFER) begin
                            cmd_err  = CERR_NONE;
                            data_err = DERR_NONE;
                            close_request(1'b1, 1'b1, 1'b0);
                            return;
                        end
                    end else if (ds[7]) begin
                        n = (RX_FULL_WORDS > WORD_CAP) ? WORD_CAP : RX_FULL_WORDS;
                        for (i = 0; i < n; i++) add_word(KIND_POP);
                    end
                end else if (ds[8]) begin
                    n = (TX_BURST_WORDS > WORD_CAP) ? WORD_CAP : TX_BURST_WORDS;
                    for (i = 0; i < n && bytes_done < total_bytes; i++) add_word(KIND_PUSH);
                end
            end

            // Transfer finish
            if (ds[5]) begin
                if (stage == STG_XFER) begin
                    cmd_err  = CERR_NONE;
                    data_err = DERR_NONE;
                    close_request(1'b1, 1'b1, 1'b0);
                    return;
                end
                if (stage == STG_XFER_RSP) begin
                    data_err = DERR_NONE;
                    stage    = STG_RSPFIN;
                end
                xclr = 1'b1;
            end

            add_status(1'b0, cclr, xclr, 1'b0, 1'b0, 1'b0);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(tracker_result_t got);
            tracker_result_t want;
            if (awaited_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("unexpected result: %s", describe(got));
                end
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.byte_offset !== want.byte_offset ||
                got.cmd_error !== want.cmd_error || got.data_error !== want.data_error ||
                got.req_complete !== want.req_complete ||
                got.cmd_clear_mask !== want.cmd_clear_mask ||
                got.clear_xfer_finish !== want.clear_xfer_finish ||
                got.ack_rx_last !== want.ack_rx_last || got.fifo_reset !== want.fifo_reset ||
                got.irq_mask_off !== want.irq_mask_off || got.last !== want.last) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result mismatch\n  expected: %s\n  actual:   %s",
                             describe(want), describe(got));
                end
            end
        endfunction

        function void close_run();
            if (awaited_results.size() != 0) begin
                failures++;
                $display("%0d predicted results never arrived", awaited_results.size());
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic        i_needs_response;
    logic        i_check_crc;
    logic        i_has_data;
    logic        i_is_read;
    logic [7:0]  i_block_count;
    logic [3:0]  i_block_size_log2;
    logic [3:0]  i_cmd_status;
    logic [8:0]  i_data_status;
    logic [6:0]  i_fifo_level;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [15:0] o_byte_offset;
    logic [1:0]  o_cmd_error;
    logic [1:0]  o_data_error;
    logic        o_req_complete;
    logic [3:0]  o_cmd_clear_mask;
    logic        o_clear_xfer_finish;
    logic        o_ack_rx_last;
    logic        o_fifo_reset;
    logic        o_irq_mask_off;
    logic        o_last;

    completion_scoreboard tracker = new();
    int cycle_count = 0;
    bit quiet_send  = 1'b0;
    bit quiet_take  = 1'b0;

    sd_host_request_completion_tracker_top uut (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic tracker_request_t make_start(logic resp, logic crc, logic data,
                                                    logic rd, logic [7:0] cnt,
                                                    logic [3:0] sh);
        tracker_request_t rq;
        rq.action          = ACT_START;
        rq.needs_response  = resp;
        rq.check_crc       = crc;
        rq.has_data        = data;
        rq.is_read         = rd;
        rq.block_count     = cnt;
        rq.block_size_log2 = sh;
        rq.cmd_status      = 4'($urandom_range(0, 15));
        rq.data_status     = 9'($urandom_range(0, 511));
        rq.fifo_level      = 7'($urandom_range(0, 127));
        return rq;
    endfunction

    function automatic tracker_request_t make_irq(logic [3:0] cs, logic [8:0] ds,
                                                  logic [6:0] lvl);
        tracker_request_t rq;
        rq.action          = ACT_IRQ;
        rq.needs_response  = 1'($urandom_range(0, 1));
        rq.check_crc       = 1'($urandom_range(0, 1));
        rq.has_data        = 1'($urandom_range(0, 1));
        rq.is_read         = 1'($urandom_range(0, 1));
        rq.block_count     = 8'($urandom_range(0, 255));
        rq.block_size_log2 = 4'($urandom_range(0, 15));
        rq.cmd_status      = cs;
        rq.data_status     = ds;
        rq.fifo_level      = lvl;
        return rq;
    endfunction

    // Mostly single progress events, with some errors and some raw noise
    function automatic tracker_request_t make_irq_event();
        logic [3:0] cs;
        logic [8:0] ds;
        logic [6:0] lvl;
        cs  = 4'b0000;
        ds  = 9'h000;
        lvl = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 15))
            0, 1: cs = 4'b0010;
            2: cs = $urandom_range(0, 1) ? 4'b1010 : 4'b1000;
            3: cs = 4'b1110;
            4, 5: ds = 9'h080;
            6, 7: ds = 9'h040;
            8, 9: ds = 9'h100;
            10: ds = 9'h020;
            11: ds = $urandom_range(0, 1) ? 9'h060 : 9'h120;
            12: ds = 9'h001 << $urandom_range(0, 4);
            13: cs = 4'b0001;
            default: begin
                cs = 4'($urandom_range(0, 15));
                ds = 9'($urandom_range(0, 511));
            end
        endcase
        return make_irq(cs, ds, lvl);
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(tracker_request_t rq);
        int gap;
        if ($urandom_range(0, 23) == 0) quiet_send = !quiet_send;
        gap = quiet_send ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action          <= rq.action;
        i_needs_response  <= rq.needs_response;
        i_check_crc       <= rq.check_crc;
        i_has_data        <= rq.has_data;
        i_is_read         <= rq.is_read;
        i_block_count     <= rq.block_count;
        i_block_size_log2 <= rq.block_size_log2;
        i_cmd_status      <= rq.cmd_status;
        i_data_status     <= rq.data_status;
        i_fifo_level      <= rq.fifo_level;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        tracker.track_request(rq);
    endtask

    // Result side: stall at random, then take and check one result
    initial begin
        int              stall;
        tracker_result_t got;
        i_ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 23) == 0) quiet_take = !quiet_take;
            stall = quiet_take ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got.kind              = o_kind;
            got.byte_offset       = o_byte_offset;
            got.cmd_error         = o_cmd_error;
            got.data_error        = o_data_error;
            got.req_complete      = o_req_complete;
            got.cmd_clear_mask    = o_cmd_clear_mask;
            got.clear_xfer_finish = o_clear_xfer_finish;
            got.ack_rx_last       = o_ack_rx_last;
            got.fifo_reset        = o_fifo_reset;
            got.irq_mask_off      = o_irq_mask_off;
            got.last              = o_last;
            tracker.check_result(got);
        end
    end

    // Request side: reset, directed cases, random sessions, drain
    initial begin
        int         random_items;
        int         events;
        logic       data;
        logic [7:0] cnt;
        logic [3:0] sh;
        random_items      = 0;
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_action          <= ACT_START;
        i_needs_response  <= 1'b0;
        i_check_crc       <= 1'b0;
        i_has_data        <= 1'b0;
        i_is_read         <= 1'b0;
        i_block_count     <= 8'd0;
        i_block_size_log2 <= 4'd0;
        i_cmd_status      <= 4'd0;
        i_data_status     <= 9'd0;
        i_fifo_level      <= 7'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Interrupt with nothing awaited, all flags raised
        send_request(make_irq(4'hF, 9'h1FF, 7'h7F));
        // Command only: sent closes, then timeout
        send_request(make_start(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 4'd0));
        send_request(make_irq(4'b0010, 9'h000, 7'h00));
        send_request(make_start(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 4'd0));
        send_request(make_irq(4'b0001, 9'h000, 7'h00));
        // Response with CRC checked fails on a bad CRC
        send_request(make_start(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 4'd0));
        send_request(make_irq(4'b0110, 9'h000, 7'h00));
        // Response without CRC check: clear bits, then response end closes
        send_request(make_start(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 4'd0));
        send_request(make_irq(4'b0110, 9'h000, 7'h00));
        send_request(make_irq(4'b1000, 9'h000, 7'h00));
        // Read: response end, receive full, receive last at full level
        send_request(make_start(1'b1, 1'b0, 1'b1, 1'b1, 8'd2, 4'd9));
        send_request(make_irq(4'b1000, 9'h000, 7'h00));
        send_request(make_irq(4'b0000, 9'h080, 7'h10));
        send_request(make_irq(4'b0000, 9'h040, 7'h7F));
        // Write of 32 bytes: bounded push, empty push, finish before response end
        send_request(make_start(1'b1, 1'b0, 1'b1, 1'b0, 8'd1, 4'd5));
        send_request(make_irq(4'b0000, 9'h100, 7'h00));
        send_request(make_irq(4'b0000, 9'h100, 7'h00));
        send_request(make_irq(4'b0000, 9'h020, 7'h00));
        send_request(make_irq(4'b1000, 9'h000, 7'h00));
        // Data errors with and without a data phase
        send_request(make_start(1'b1, 1'b0, 1'b1, 1'b1, 8'd128, 4'd9));
        send_request(make_irq(4'b0000, 9'h001, 7'h00));
        send_request(make_start(1'b0, 1'b0, 1'b1, 1'b0, 8'd1, 4'd0));
        send_request(make_irq(4'b0000, 9'h002, 7'h00));
        send_request(make_start(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 4'd0));
        send_request(make_irq(4'b0000, 9'h004, 7'h00));
        send_request(make_start(1'b1, 1'b1, 1'b1, 1'b0, 8'd255, 4'd15));
        send_request(make_irq(4'b0000, 9'h010, 7'h00));

        // Random sessions: a start and a short run of events, or a stray interrupt
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                send_request(make_irq(4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                                      7'($urandom_range(0, 127))));
                random_items++;
            end else begin
                data = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 7) == 0) begin
                    cnt = 8'($urandom_range(0, 255));
                    sh  = 4'($urandom_range(0, 15));
                end else begin
                    cnt = 8'($urandom_range(0, 8));
                    sh  = 4'($urandom_range(0, 9));
                end
                send_request(make_start(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                                        data, 1'($urandom_range(0, 1)), cnt, sh));
                random_items++;
                events = $urandom_range(1, 6);
                repeat (events) begin
                    send_request(make_irq_event());
                    random_items++;
                end
            end
        end

        // Drop valid and let the last results drain
        i_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.close_run();
        if (tracker.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
